// ----- design/resist_development_rate_assert.svh -----
// assertion macros for the development rate block
`ifndef RESIST_DEVELOPMENT_RATE_ASSERT_SVH
`define RESIST_DEVELOPMENT_RATE_ASSERT_SVH

// same-cycle implication, off while in reset
`define RDR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication, off while in reset
`define RDR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

// checks the cycle after reset is held
`define RDR_ASSERT_RST(lbl, clk, rstn, cons) \
    lbl: assert property (@(posedge clk) !(rstn) |=> (cons)) \
        else $error("%m: reset check failed");

`endif

// ----- design/rdr_pkg.sv -----
`default_nettype none
package rdr_pkg;

    localparam int PW_FRAC  = 30;
    localparam int LOG_BITS = 16;
    localparam logic [30:0] PW_ONE = 31'h4000_0000;

    localparam int DIV_BITS = 32;
    localparam int PW_LAT   = 2 * LOG_BITS + 3;
    localparam int MIX_LAT  = 4;
    localparam int DIV_LAT  = DIV_BITS + 1;

    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_RATE_MAX  = 3'd0,
        REG_RATE_MIN  = 3'd1,
        REG_RATE_RES  = 3'd2,
        REG_EXP_DIS   = 3'd3,
        REG_EXP_INH   = 3'd4
    } t_reg_idx;

    // truncating integer square root, evaluated at elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
        logic [63:0] a;
        logic [63:0] res;
        logic [63:0] b;
        a = a_in;
        res = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (a >= res + b) begin
                a = a - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // factor 2^(-2^-k) in q1.30 through the truncating root chain
    function automatic logic [30:0] pw_factor(input int k);
        logic [63:0] t;
        t = isqrt64(64'd1 << 59);
        for (int j = 1; j < k; j++) begin
            t = isqrt64(t << 30);
        end
        return t[30:0];
    endfunction

endpackage
`default_nettype wire

// ----- design/rdr_in_if.sv -----
`default_nettype none
interface rdr_in_if #(parameter int CONC_FRAC_BITS = 16);
    logic                    valid;
    logic                    ready;
    logic [CONC_FRAC_BITS:0] inhibitor_conc;

    modport source(output valid, output inhibitor_conc, input ready);
    modport sink(input valid, input inhibitor_conc, output ready);
endinterface
`default_nettype wire

// ----- design/rdr_out_if.sv -----
`default_nettype none
interface rdr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] dev_rate;
    logic        saturated;

    modport source(output valid, output dev_rate, output saturated, input ready);
    modport sink(input valid, input dev_rate, input saturated, output ready);
endinterface
`default_nettype wire

// ----- design/rdr_pow.sv -----
`default_nettype none
module rdr_pow #(
    parameter int CONC_FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [CONC_FRAC_BITS:0] i_base,
    input  logic [15:0]             i_expo,
    output logic [30:0]             o_pow
);
    localparam int F   = CONC_FRAC_BITS;
    localparam int NS  = rdr_pkg::LOG_BITS;
    localparam int SHW = $clog2(F + 1);
    localparam int MW  = SHW + NS;
    localparam int YW  = MW + 8;

    typedef struct packed {
        logic [SHW-1:0] sh;
        logic [15:0]    e;
        logic           zero;
        logic           unit;
    } t_lctl;

    typedef struct packed {
        logic zero;
        logic unit;
    } t_ectl;

    logic [30:0]    r_z    [0:NS-1];
    logic [NS-1:0]  r_frac [0:NS];
    t_lctl          r_lc   [0:NS];
    logic [YW-1:0]  r_ey   [0:NS];
    t_ectl          r_ef   [0:NS];
    logic [30:0]    r_r    [1:NS];
    logic [30:0]    r_pow;

    logic [SHW-1:0] lead;
    logic [30:0]    z_init;

    // leading one and normalize to q1.30
    always_comb begin
        lead = '0;
        for (int i = 0; i <= F; i++) begin
            if (i_base[i]) begin
                lead = SHW'(i);
            end
        end
        z_init = 31'(i_base) << (5'(rdr_pkg::PW_FRAC) - 5'(lead));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z[0]       <= z_init;
            r_frac[0]    <= '0;
            r_lc[0].sh   <= SHW'(F) - lead;
            r_lc[0].e    <= i_expo;
            r_lc[0].zero <= (i_base == '0);
            r_lc[0].unit <= (i_expo == '0);
        end
    end

    // one squaring per stage gives one log2 fraction bit
    for (genvar j = 1; j <= NS; j++) begin : g_sq
        logic [61:0] sq;
        logic [31:0] sr;
        assign sq = 62'(r_z[j-1]) * 62'(r_z[j-1]);
        assign sr = sq[61:30];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_frac[j] <= {r_frac[j-1][NS-2:0], sr[31]};
                r_lc[j]   <= r_lc[j-1];
            end
        end
        if (j < NS) begin : g_z
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_z[j] <= sr[31] ? sr[31:1] : sr[30:0];
                end
            end
        end
    end

    logic [MW-1:0]    mlog;
    logic [MW+15:0]   ym;
    assign mlog = {r_lc[NS].sh, NS'(0)} - MW'(r_frac[NS]);
    assign ym   = (MW+16)'(r_lc[NS].e) * (MW+16)'(mlog);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ey[0]      <= ym[MW+15:8];
            r_ef[0].zero <= r_lc[NS].zero;
            r_ef[0].unit <= r_lc[NS].unit;
        end
    end

    // exp2 of the fraction: one constant factor per stage
    for (genvar k = 1; k <= NS; k++) begin : g_ex
        localparam logic [30:0] TK = rdr_pkg::pw_factor(k);
        logic [30:0] r_src;
        logic [61:0] pr;
        if (k == 1) begin : g_first
            assign r_src = rdr_pkg::PW_ONE;
        end else begin : g_next
            assign r_src = r_r[k-1];
        end
        assign pr = 62'(r_src) * 62'(TK);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[k]  <= r_ey[k-1][NS-k] ? pr[60:30] : r_src;
                r_ey[k] <= r_ey[k-1];
                r_ef[k] <= r_ef[k-1];
            end
        end
    end

    logic [YW-17:0] ip;
    assign ip = r_ey[NS][YW-1:NS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ef[NS].unit) begin
                r_pow <= rdr_pkg::PW_ONE;
            end else if (r_ef[NS].zero || (ip >= (YW-16)'(31))) begin
                r_pow <= '0;
            end else begin
                r_pow <= r_r[NS] >> ip[4:0];
            end
        end
    end

    assign o_pow = r_pow;
endmodule
`default_nettype wire

// ----- design/rdr_div.sv -----
`default_nettype none
module rdr_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_mid,
    input  logic [31:0] i_lo,
    input  logic [63:0] i_den,
    input  logic        i_bad,
    output logic [31:0] o_dev_rate,
    output logic        o_sat
);
    localparam int NB = rdr_pkg::DIV_BITS;

    logic [63:0]   r_rem [0:NB-1];
    logic [31:0]   r_lo  [0:NB-1];
    logic [63:0]   r_den [0:NB-1];
    logic [NB-1:0] r_q   [0:NB];
    logic          r_sat [0:NB];

    // saturate on a bad config, or when the quotient passes 32 bits as the upper part already reaches the divisor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_mid;
            r_lo[0]  <= i_lo;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_sat[0] <= i_bad || (i_mid >= i_den);
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar s = 1; s <= NB; s++) begin : g_dv
        logic [63:0] rs;
        logic        ge;
        assign rs = {r_rem[s-1][62:0], r_lo[s-1][NB-s]};
        assign ge = (rs >= r_den[s-1]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s]   <= {r_q[s-1][NB-2:0], ge};
                r_sat[s] <= r_sat[s-1];
            end
        end
        if (s < NB) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= ge ? (rs - r_den[s-1]) : rs;
                    r_lo[s]  <= r_lo[s-1];
                    r_den[s] <= r_den[s-1];
                end
            end
        end
    end

    assign o_dev_rate = r_sat[NB] ? '1 : r_q[NB];
    assign o_sat      = r_sat[NB];
endmodule
`default_nettype wire

// ----- design/resist_development_rate.sv -----
// resist development rate, enhanced mack model
// i_conc carries one inhibitor concentration item (q1.CONC_FRAC_BITS, clamped
// to one); o_rate returns one item per input: dev_rate in q16.16 and the
// saturated flag, set with an all-ones rate on zero rate_min or rate_resin,
// or when the quotient does not fit 32 bits.
// the apb port holds rate_max, rate_min, rate_resin at 0x0, 0x4, 0x8 and the
// two q8.8 exponents at 0xc, 0x10; pready is always high, write while idle.
// the pipe runs through the two power units side by side (16 squaring
// stages for log2, 16 factor stages for exp2), the numerator and
// denominator products, then the one-bit-per-stage divider.
// throughput is one item per cycle while results are taken.
// the whole pipe advances together; when the result at the output is not
// taken, every stage holds and i_conc.ready drops until it is taken.
// reset empties the pipe and loads the register defaults.
`default_nettype none
`include "resist_development_rate_assert.svh"
module resist_development_rate #(
    parameter int CONC_FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rdr_in_if.sink                      i_conc,
    rdr_out_if.source                   o_rate,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rdr_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    localparam int F   = CONC_FRAC_BITS;
    localparam int LAT = rdr_pkg::PW_LAT + rdr_pkg::MIX_LAT + rdr_pkg::DIV_LAT;
    localparam logic [F:0] ONE_C = {1'b1, {F{1'b0}}};

    logic [31:0] r_rate_max;
    logic [31:0] r_rate_min;
    logic [31:0] r_rate_res;
    logic [15:0] r_exp_dis;
    logic [15:0] r_exp_inh;

    rdr_pkg::t_reg_idx reg_idx;
    assign reg_idx = rdr_pkg::t_reg_idx'(paddr[4:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_max <= 32'd6553600;
            r_rate_min <= 32'd32768;
            r_rate_res <= 32'd655360;
            r_exp_dis  <= 16'd1024;
            r_exp_inh  <= 16'd5120;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                rdr_pkg::REG_RATE_MAX: r_rate_max <= pwdata;
                rdr_pkg::REG_RATE_MIN: r_rate_min <= pwdata;
                rdr_pkg::REG_RATE_RES: r_rate_res <= pwdata;
                rdr_pkg::REG_EXP_DIS:  r_exp_dis  <= pwdata[15:0];
                rdr_pkg::REG_EXP_INH:  r_exp_inh  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rdr_pkg::REG_RATE_MAX: prdata = r_rate_max;
            rdr_pkg::REG_RATE_MIN: prdata = r_rate_min;
            rdr_pkg::REG_RATE_RES: prdata = r_rate_res;
            rdr_pkg::REG_EXP_DIS:  prdata = {16'd0, r_exp_dis};
            rdr_pkg::REG_EXP_INH:  prdata = {16'd0, r_exp_inh};
            default:               prdata = '0;
        endcase
    end

    logic [LAT-1:0] r_vld;
    logic           adv;

    assign adv          = !r_vld[LAT-1] || o_rate.ready;
    assign i_conc.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], i_conc.valid};
        end
    end

    logic [F:0]  pac;
    logic [F:0]  base_a;
    logic [30:0] pw_a;
    logic [30:0] pw_b;

    assign pac    = (i_conc.inhibitor_conc > ONE_C) ? ONE_C : i_conc.inhibitor_conc;
    assign base_a = ONE_C - pac;

    // a = (1-pac)^n, b = pac^l
    rdr_pow #(.CONC_FRAC_BITS(CONC_FRAC_BITS)) u_pow_a (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_base (base_a),
        .i_expo (r_exp_dis),
        .o_pow  (pw_a)
    );

    rdr_pow #(.CONC_FRAC_BITS(CONC_FRAC_BITS)) u_pow_b (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_base (pac),
        .i_expo (r_exp_inh),
        .o_pow  (pw_b)
    );

    logic [62:0] r_p_ra;
    logic [62:0] r_p_ma;
    logic [62:0] r_p_mb;
    logic [62:0] r_p_rb;
    logic [63:0] r_num;
    logic [63:0] r_den2;
    logic [63:0] r_pl;
    logic [63:0] r_ph;
    logic [63:0] r_den3;
    logic [63:0] r_mid;
    logic [31:0] r_lo;
    logic [63:0] r_den4;

    // num = resin*(1-a) + max*a, den = min*(1-b) + resin*b, then min*num
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_ra <= 63'(r_rate_res) * 63'(rdr_pkg::PW_ONE - pw_a);
            r_p_ma <= 63'(r_rate_max) * 63'(pw_a);
            r_p_mb <= 63'(r_rate_min) * 63'(rdr_pkg::PW_ONE - pw_b);
            r_p_rb <= 63'(r_rate_res) * 63'(pw_b);

            r_num  <= 64'(r_p_ra) + 64'(r_p_ma);
            r_den2 <= 64'(r_p_mb) + 64'(r_p_rb);

            r_pl   <= 64'(r_rate_min) * 64'(r_num[31:0]);
            r_ph   <= 64'(r_rate_min) * 64'(r_num[63:32]);
            r_den3 <= r_den2;

            r_mid  <= {32'd0, r_pl[63:32]} + r_ph;
            r_lo   <= r_pl[31:0];
            r_den4 <= r_den3;
        end
    end

    logic bad_cfg;
    assign bad_cfg = (r_rate_min == '0) || (r_rate_res == '0);

    rdr_div u_div (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_mid      (r_mid),
        .i_lo       (r_lo),
        .i_den      (r_den4),
        .i_bad      (bad_cfg),
        .o_dev_rate (o_rate.dev_rate),
        .o_sat      (o_rate.saturated)
    );

    assign o_rate.valid = r_vld[LAT-1];

    `RDR_ASSERT_RST(a_reset_empty, i_clk, i_rst_n, !o_rate.valid)
    `RDR_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, o_rate.valid && !o_rate.ready, $stable(r_vld))
    `RDR_ASSERT_IMP(a_sat_ones, i_clk, i_rst_n, o_rate.valid && o_rate.saturated, &o_rate.dev_rate)

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
module testbench;

    localparam int CFB = 16;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam int LATENCY = 72;

    typedef struct packed {
        logic [31:0] rate;
        logic        sat;
    } t_rate_item;

    typedef struct {
        logic [16:0] conc;
        bit          typed;
        logic [31:0] rate;
        logic        sat;
    } t_conc_row;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [rdr_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;

    rdr_in_if #(.CONC_FRAC_BITS(CFB)) conc_if();
    rdr_out_if rate_if();

    resist_development_rate #(.CONC_FRAC_BITS(CFB)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_conc(conc_if), .o_rate(rate_if),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // model copy of the registers
    logic [31:0] m_rate_max, m_rate_min, m_rate_resin;
    logic [15:0] m_exp_dis, m_exp_inh;
    logic [63:0] halving_fac [1:16];

    t_rate_item expected_rates[$];
    int errors = 0;
    int ready_pct = 100;

    // reset config: pac 0 gives rate_max, pac one (or above, clamped) gives rate_min
    t_conc_row reset_rows [12] = '{
        '{17'd0,       1, 32'd6553600, 1'b0},
        '{17'd65536,   1, 32'd32768,   1'b0},
        '{17'h1FFFF,   1, 32'd32768,   1'b0},
        '{17'd65537,   1, 32'd32768,   1'b0},
        '{17'd1,       0, 32'd0,       1'b0},
        '{17'd65535,   0, 32'd0,       1'b0},
        '{17'd32768,   0, 32'd0,       1'b0},
        '{17'd16384,   0, 32'd0,       1'b0},
        '{17'd49152,   0, 32'd0,       1'b0},
        '{17'h0AAAA,   0, 32'd0,       1'b0},
        '{17'h05555,   0, 32'd0,       1'b0},
        '{17'd256,     0, 32'd0,       1'b0}
    };
    // zero rate_min saturates regardless of concentration
    t_conc_row zero_min_rows [4] = '{
        '{17'd0,       1, 32'hFFFF_FFFF, 1'b1},
        '{17'd65536,   1, 32'hFFFF_FFFF, 1'b1},
        '{17'd30000,   1, 32'hFFFF_FFFF, 1'b1},
        '{17'h1FFFF,   1, 32'hFFFF_FFFF, 1'b1}
    };

    function automatic logic [63:0] root64(logic [63:0] a_in);
        logic [63:0] a, res, b;
        a = a_in;
        res = '0;
        b = 64'd1 << 62;
        while (b > a) b = b >> 2;
        while (b != 0) begin
            if (a >= res + b) begin
                a = a - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // v in q1.16 up to one, e in q8.8, result q1.30
    function automatic logic [63:0] conc_power(logic [63:0] v, logic [15:0] e);
        int p;
        logic [63:0] z, frac, m, y, r, f, ip;
        if (e == 0) return ONE_Q30;
        if (v == 0) return 64'd0;
        p = 0;
        while (p < 63 && (v >> (p + 1)) != 0) p++;
        z = v << (30 - p);
        frac = 0;
        for (int i = 0; i < 16; i++) begin
            z = (z * z) >> 30;
            frac = frac << 1;
            if (z >= (64'd2 << 30)) begin
                z = z >> 1;
                frac = frac | 1;
            end
        end
        m = (64'(CFB - p) << 16) - frac;
        y = ({48'd0, e} * m) >> 8;
        ip = y >> 16;
        f = y & 64'hFFFF;
        if (ip >= 31) return 64'd0;
        r = ONE_Q30;
        for (int k = 1; k <= 16; k++) begin
            if (f[16-k]) r = (r * halving_fac[k]) >> 30;
        end
        return r >> ip;
    endfunction

    function automatic t_rate_item predict_rate(logic [16:0] conc);
        logic [63:0] pac, a, b, num, den;
        logic [127:0] prod, q;
        t_rate_item res;
        pac = {47'd0, conc};
        if (pac > 64'd65536) pac = 64'd65536;
        res.rate = 32'hFFFF_FFFF;
        res.sat = 1'b1;
        if (m_rate_min == 0 || m_rate_resin == 0) return res;
        a = conc_power(64'd65536 - pac, m_exp_dis);
        b = conc_power(pac, m_exp_inh);
        num = {32'd0, m_rate_resin} * (ONE_Q30 - a) + {32'd0, m_rate_max} * a;
        den = {32'd0, m_rate_min} * (ONE_Q30 - b) + {32'd0, m_rate_resin} * b;
        if (den == 0) return res;
        prod = {96'd0, m_rate_min} * {64'd0, num};
        q = prod / {64'd0, den};
        if (q[127:32] != 0) return res;
        res.rate = q[31:0];
        res.sat = 1'b0;
        return res;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

    // result side: compare and random stall
    always @(posedge i_clk) begin
        t_rate_item want;
        if (i_rst_n && rate_if.valid && rate_if.ready) begin
            if (expected_rates.size() == 0) begin
                $display("%0t: unexpected item rate=%h sat=%b", $realtime,
                         rate_if.dev_rate, rate_if.saturated);
                errors++;
            end else begin
                want = expected_rates.pop_front();
                if (rate_if.dev_rate !== want.rate || rate_if.saturated !== want.sat) begin
                    $display("%0t: expected rate=%h sat=%b, got rate=%h sat=%b",
                             $realtime, want.rate, want.sat,
                             rate_if.dev_rate, rate_if.saturated);
                    errors++;
                end
            end
        end
        rate_if.ready <= ($urandom_range(0, 99) < ready_pct);
    end

    task automatic reg_write(rdr_pkg::t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= rdr_pkg::ADDR_W'(4 * int'(idx));
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            rdr_pkg::REG_RATE_MAX: m_rate_max = val;
            rdr_pkg::REG_RATE_MIN: m_rate_min = val;
            rdr_pkg::REG_RATE_RES: m_rate_resin = val;
            rdr_pkg::REG_EXP_DIS:  m_exp_dis = val[15:0];
            rdr_pkg::REG_EXP_INH:  m_exp_inh = val[15:0];
            default: ;
        endcase
    endtask

    task automatic load_config(logic [31:0] rmax, logic [31:0] rmin, logic [31:0] rres,
                               logic [15:0] en, logic [15:0] el);
        reg_write(rdr_pkg::REG_RATE_MAX, rmax);
        reg_write(rdr_pkg::REG_RATE_MIN, rmin);
        reg_write(rdr_pkg::REG_RATE_RES, rres);
        reg_write(rdr_pkg::REG_EXP_DIS, {16'd0, en});
        reg_write(rdr_pkg::REG_EXP_INH, {16'd0, el});
    endtask

    int burst_left = 0;

    task automatic send_conc(logic [16:0] conc, t_rate_item want);
        conc_if.valid <= 1'b1;
        conc_if.inhibitor_conc <= conc;
        expected_rates.push_back(want);
        @(posedge i_clk);
        while (!conc_if.ready) @(posedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                conc_if.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic run_rows(t_conc_row rows[]);
        t_rate_item want;
        foreach (rows[i]) begin
            if (rows[i].typed) begin
                want.rate = rows[i].rate;
                want.sat = rows[i].sat;
            end else begin
                want = predict_rate(rows[i].conc);
            end
            send_conc(rows[i].conc, want);
        end
    endtask

    // called once the last item has been taken
    task automatic drain();
        conc_if.valid <= 1'b0;
        while (expected_rates.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic logic [16:0] random_conc();
        case ($urandom_range(0, 5))
            0: return 17'($urandom_range(0, 131071));
            1: return 17'($urandom_range(0, 255));
            2: return 17'($urandom_range(65280, 65536));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic run_random(int n);
        logic [16:0] c;
        for (int i = 0; i < n; i++) begin
            c = random_conc();
            send_conc(c, predict_rate(c));
        end
    endtask

    initial begin
        logic [63:0] t;
        t = root64(64'd1 << 59);
        for (int k = 1; k <= 16; k++) begin
            halving_fac[k] = t;
            t = root64(t << 30);
        end
        m_rate_max = 32'd6553600;
        m_rate_min = 32'd32768;
        m_rate_resin = 32'd655360;
        m_exp_dis = 16'd1024;
        m_exp_inh = 16'd5120;

        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        conc_if.valid = 1'b0;
        conc_if.inhibitor_conc = '0;
        rate_if.ready = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_rows(reset_rows);
        drain();
        reg_write(rdr_pkg::REG_RATE_MIN, 32'd0);
        run_rows(zero_min_rows);
        drain();

        // defaults and fixed extremes first, then random settings
        for (int ph = 0; ph < 9; ph++) begin
            ready_pct = (ph % 3 == 0) ? 100 : $urandom_range(30, 95);
            case (ph)
                0: load_config(32'd6553600, 32'd32768, 32'd655360, 16'd1024, 16'd5120);
                1: load_config(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 16'd256, 16'd0);
                2: load_config(32'd0, 32'hFFFF_FFFF, 32'd1, 16'hFFFF, 16'hFFFF);
                3: load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd256, 16'd256);
                4: load_config(32'd1000, 32'd500, 32'd0, 16'd512, 16'd768);
                5: load_config(32'd100, 32'd100000, 32'd10, 16'd100, 16'd3000);
                default: load_config($urandom, $urandom_range(1, 32'h00FF_FFFF),
                                     $urandom_range(1, 32'h0FFF_FFFF),
                                     16'($urandom_range(256, 65535)),
                                     16'($urandom_range(0, 65535)));
            endcase
            run_random(45);
            drain();
        end

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
